// ===== rtl/bbtb_pkg.sv =====
package bbtb_pkg;

  typedef struct packed {
    logic        operation;
    logic [63:0] bundle_pc;
    logic [15:0] taken_counters;
    logic [2:0]  miss_slot;
    logic [63:0] miss_target;
    logic [31:0] instruction_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic        slot_hit;
    logic [2:0]  branch_kind;
    logic [63:0] slot_target;
    logic        last_slot;
    logic [3:0]  bundle_length;
    logic [63:0] next_fetch_pc;
  } out_item_t;

  localparam logic       OP_LOOKUP = 1'b0;
  localparam logic       OP_INSTALL = 1'b1;
  localparam logic [2:0] KIND_COND = 3'd0;
  localparam logic [2:0] KIND_JUMP = 3'd1;
  localparam logic [2:0] KIND_CALL = 3'd2;
  localparam logic [2:0] KIND_JUMP_IND = 3'd3;
  localparam logic [2:0] KIND_CALL_IND = 3'd4;
  localparam logic [2:0] KIND_RET = 3'd5;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL = 7'h6F;
  localparam logic [6:0] OPC_JALR = 7'h67;
  localparam logic [3:0] LIMIT_RESET = 4'd2;
  localparam logic [0:0] REG_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT
  } state_t;

  // Decodes the installed instruction; valid is low for a non-branch opcode.
  function automatic logic [3:0] decode_kind(input logic [31:0] w);
    logic [6:0] op;
    logic [4:0] rd;
    logic [4:0] rs1;
    op = w[6:0];
    rd = w[11:7];
    rs1 = w[19:15];
    case (op)
      OPC_BRANCH: decode_kind = {1'b1, KIND_COND};
      OPC_JAL: decode_kind = {1'b1, (rd == 5'd1) ? KIND_CALL : KIND_JUMP};
      OPC_JALR: begin
        if (rd == 5'd0 && rs1 == 5'd1) decode_kind = {1'b1, KIND_RET};
        else if (rd == 5'd1) decode_kind = {1'b1, KIND_CALL_IND};
        else decode_kind = {1'b1, KIND_JUMP_IND};
      end
      default: decode_kind = 4'd0;
    endcase
  endfunction

endpackage

// ===== rtl/bbtb_cfg.sv =====
module bbtb_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  limit
);
  import bbtb_pkg::*;

  // Single limit register at address zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_LIMIT) begin
      limit <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LIMIT) ? {28'd0, limit} : 32'd0;
endmodule

// ===== rtl/banked_btb_fetch_bundle_unit.sv =====
// Banked set-associative branch target buffer with true LRU per set. A lookup
// walks the fetch bundle one slot at a time through one shared tag/age scan:
// each slot passes through a read state, a scan over all WAYS ways, a write
// state on a hit, and an emit state for its result, which holds while
// out_ready is low. An install passes through read, scan and write states. After
// reset a clearing pass (one set per cycle) initializes valid bits and ages;
// no transaction is accepted until it ends. The block takes one item at a time.
module banked_btb_fetch_bundle_unit #(
  parameter int BANKS = 8,
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbtb_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bbtb_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bbtb_pkg::*;

  localparam int BB = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int BS = (BANKS > 1) ? $clog2(BANKS) : 0;
  localparam int SB = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROWS = BANKS * SETS;
  localparam int RB = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TB = 62 - BS - SB;
  localparam int PB = $clog2(BANKS + 1);

  typedef struct packed {
    logic          valid;
    logic [TB-1:0] tag;
    logic [2:0]    kind;
    logic [63:0]   target;
  } way_t;

  logic [3:0] limit;

  bbtb_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .limit(limit)
  );

  // One memory row per set holds all ways and their ages.
  way_t [WAYS-1:0]         mem_way [ROWS];
  logic [WAYS-1:0][WB-1:0] mem_age [ROWS];
  way_t [WAYS-1:0]         row_way;
  logic [WAYS-1:0][WB-1:0] row_age;

  state_t state, state_next;
  in_item_t item;
  logic [PB-1:0] pos;
  logic [RB-1:0] row;
  logic [TB-1:0] tag;
  logic [WB-1:0] scan, hit_way, victim;
  logic          hit;
  logic [15:0]   ctr;
  logic [3:0]    conds;
  logic [RB-1:0] clr;
  logic [2:0]    ikind;
  logic          done;

  // Address of the current slot.
  logic [61:0] ia;
  always_comb begin
    ia = item.bundle_pc[63:2] + 62'(item.operation == OP_INSTALL ?
         {{(PB>3?PB-3:0){1'b0}}, item.miss_slot} : pos);
  end
  logic [RB-1:0] row_addr;
  logic [BB-1:0] bank_f;
  logic [RB-1:0] set_f;
  always_comb begin
    bank_f = (BANKS > 1) ? BB'(ia) : '0;
    set_f = (SETS > 1) ? RB'((ia >> BS) & ((62'd1 << SB) - 62'd1)) : '0;
    row_addr = RB'(RB'(bank_f) * RB'(SETS) + set_f);
  end

  // Current way under scan, and the age of the chosen way.
  way_t          cur_way;
  logic [WB-1:0] cur_age, sel_age;
  logic          scan_match;
  always_comb begin
    cur_way = row_way[scan];
    cur_age = row_age[scan];
    sel_age = row_age[hit ? hit_way : victim];
    scan_match = cur_way.valid && cur_way.tag == tag;
  end

  logic       taken;
  logic [3:0] len;
  always_comb begin
    taken = (ctr[1:0] >= 2'd2);
    len = 4'(pos) + 4'd1;
  end

  // Result of the current slot on a miss and on a hit.
  logic [2:0]  hit_kind;
  logic [63:0] hit_target;
  logic        miss_end, hit_end;
  out_item_t   miss_out, hit_out;
  always_comb begin
    hit_kind = row_way[hit_way].kind;
    hit_target = row_way[hit_way].target;
    miss_end = (pos == PB'(BANKS - 1));
    miss_out = '0;
    miss_out.slot_index = 3'(pos);
    if (miss_end) begin
      miss_out.last_slot = 1'b1;
      miss_out.bundle_length = 4'(BANKS);
      miss_out.next_fetch_pc = item.bundle_pc + 64'(BANKS * 4);
    end
    hit_end = 1'b1;
    hit_out = '0;
    hit_out.slot_index = 3'(pos);
    hit_out.slot_hit = 1'b1;
    hit_out.branch_kind = hit_kind;
    hit_out.slot_target = hit_target;
    if (hit_kind == KIND_COND) begin
      if (taken || (conds + 4'd1) == limit) begin
        hit_out.last_slot = 1'b1;
        hit_out.bundle_length = len;
        hit_out.next_fetch_pc = taken ? hit_target :
                                item.bundle_pc + {58'd0, len, 2'b00};
      end else if (miss_end) begin
        hit_out.last_slot = 1'b1;
        hit_out.bundle_length = 4'(BANKS);
        hit_out.next_fetch_pc = item.bundle_pc + 64'(BANKS * 4);
      end else begin
        hit_end = 1'b0;
      end
    end else begin
      hit_out.last_slot = 1'b1;
      hit_out.bundle_length = len;
      hit_out.next_fetch_pc = hit_target;
    end
  end

  logic [3:0] dec;
  assign dec = decode_kind(in_data.instruction_word);

  // Next state; an install of a non-branch opcode is accepted and dropped.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == RB'(ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid && !(in_data.operation == OP_INSTALL && !dec[3]))
          state_next = ST_READ;
      end
      ST_READ: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan == WB'(WAYS - 1)) begin
          if (item.operation == OP_INSTALL) state_next = ST_WRITE;
          else if (hit || scan_match) state_next = ST_WRITE;
          else state_next = ST_EMIT;
        end
      end
      ST_WRITE: state_next = (item.operation == OP_INSTALL) ? ST_IDLE : ST_EMIT;
      ST_EMIT: begin
        if (out_ready) state_next = done ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + RB'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item <= in_data;
        pos <= '0;
        ctr <= in_data.taken_counters;
        conds <= '0;
        ikind <= dec[2:0];
        done <= 1'b0;
      end
      ST_READ: begin
        row <= row_addr;
        tag <= ia[61-:TB];
        row_way <= mem_way[row_addr];
        row_age <= mem_age[row_addr];
        scan <= '0;
        hit <= 1'b0;
        victim <= '0;
        hit_way <= '0;
      end
      ST_SCAN: begin
        if (!hit && scan_match) begin
          hit <= 1'b1;
          hit_way <= scan;
        end
        if (!hit && cur_age == WB'(WAYS - 1)) victim <= scan;
        scan <= scan + WB'(1);
        if (item.operation == OP_LOOKUP && scan == WB'(WAYS - 1) &&
            !(hit || scan_match)) begin
          out_data <= miss_out;
          if (miss_end) done <= 1'b1;
        end
      end
      ST_WRITE: begin
        if (item.operation == OP_LOOKUP) begin
          out_data <= hit_out;
          if (hit_end) done <= 1'b1;
          if (hit_kind == KIND_COND) begin
            ctr <= ctr >> 2;
            conds <= conds + 4'd1;
          end
        end
      end
      ST_EMIT: if (out_ready) pos <= pos + PB'(1);
      default: ;
    endcase
  end

  // Memory writes: clearing pass, then install or LRU touch.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      for (int i = 0; i < WAYS; i++) begin
        mem_way[clr][i].valid <= 1'b0;
        mem_age[clr][i] <= WB'(i);
      end
    end else if (state == ST_WRITE) begin
      for (int i = 0; i < WAYS; i++) begin
        if (WB'(i) == (hit ? hit_way : victim)) mem_age[row][i] <= '0;
        else if (row_age[i] < sel_age) mem_age[row][i] <= row_age[i] + WB'(1);
        else mem_age[row][i] <= row_age[i];
      end
      if (item.operation == OP_INSTALL) begin
        mem_way[row][hit ? hit_way : victim] <= '{valid: 1'b1, tag: tag,
                                                  kind: ikind, target: item.miss_target};
      end
    end
  end

endmodule

// ===== tb/sv/banked_btb_fetch_bundle_unit_test.sv =====
module banked_btb_fetch_bundle_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bbtb_pkg::*;

  localparam int BANKS = 8;
  localparam int SETS = 64;
  localparam int WAYS = 4;
  localparam int ENTRIES = BANKS * SETS * WAYS;
  localparam int STALL_MAX = 17;
  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  banked_btb_fetch_bundle_unit #(.BANKS(BANKS), .SETS(SETS), .WAYS(WAYS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the buffer contents and the bundle limit.
  bit          btb_valid [ENTRIES];
  logic [52:0] btb_tag [ENTRIES];
  logic [1:0]  btb_age [ENTRIES];
  logic [2:0]  btb_kind [ENTRIES];
  logic [63:0] btb_target [ENTRIES];
  logic [3:0]  bundle_limit;

  in_item_t  pending_items[$];
  out_item_t expected_slots[$];
  bit        stall_enable;
  int        error_count;
  int        lookup_count;
  int        install_count;
  int        slot_count;
  int        quiet_cycles;

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void reset_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      btb_valid[i] = 1'b0;
      btb_tag[i] = '0;
      btb_kind[i] = '0;
      btb_target[i] = '0;
      btb_age[i] = 2'(i % WAYS);
    end
    bundle_limit = LIMIT_RESET;
  endfunction

  // Set base entry and tag of one bundle slot.
  function automatic void locate_slot(input logic [63:0] pc, input int pos,
                                      output int base, output logic [52:0] tag);
    logic [61:0] ia;
    ia = pc[63:2] + 62'(pos);
    base = int'({ia[2:0], ia[8:3]}) * WAYS;
    tag = ia[61:9];
  endfunction

  // Returns the hitting way, or the least recently used way on a miss.
  function automatic int pick_way(input int base, input logic [52:0] tag,
                                  output bit hit);
    int victim;
    victim = 0;
    hit = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (btb_valid[base + w] && btb_tag[base + w] == tag) begin
        hit = 1'b1;
        return w;
      end
      if (btb_age[base + w] == 2'(WAYS - 1)) victim = w;
    end
    return victim;
  endfunction

  function automatic void make_recent(input int base, input int way);
    logic [1:0] a;
    a = btb_age[base + way];
    for (int w = 0; w < WAYS; w++)
      if (btb_age[base + w] < a) btb_age[base + w]++;
    btb_age[base + way] = '0;
  endfunction

  // Applies one accepted transaction to the shadow buffer and queues its results.
  function automatic void predict_bundle(input in_item_t item);
    int base;
    int way;
    bit hit;
    bit done;
    bit known;
    bit taken;
    logic [52:0] tag;
    logic [15:0] ctr;
    logic [3:0] conds;
    logic [3:0] len;
    logic [63:0] next_pc;
    logic [2:0] kind;
    logic [6:0] opc;
    logic [4:0] rd;
    logic [4:0] rs1;
    out_item_t slots[BANKS];
    if (item.operation == OP_INSTALL) begin
      install_count++;
      opc = item.instruction_word[6:0];
      rd = item.instruction_word[11:7];
      rs1 = item.instruction_word[19:15];
      known = 1'b1;
      kind = KIND_COND;
      if (opc == OPC_BRANCH) kind = KIND_COND;
      else if (opc == OPC_JAL) kind = (rd == 5'd1) ? KIND_CALL : KIND_JUMP;
      else if (opc == OPC_JALR) begin
        if (rd == 5'd0 && rs1 == 5'd1) kind = KIND_RET;
        else if (rd == 5'd1) kind = KIND_CALL_IND;
        else kind = KIND_JUMP_IND;
      end else known = 1'b0;
      if (!known) return;
      locate_slot(item.bundle_pc, int'(item.miss_slot), base, tag);
      way = pick_way(base, tag, hit);
      btb_valid[base + way] = 1'b1;
      btb_tag[base + way] = tag;
      make_recent(base, way);
      btb_kind[base + way] = kind;
      btb_target[base + way] = item.miss_target;
      return;
    end
    lookup_count++;
    ctr = item.taken_counters;
    conds = '0;
    done = 1'b0;
    len = 4'(BANKS);
    next_pc = item.bundle_pc + 64'(BANKS * 4);
    for (int pos = 0; pos < BANKS && !done; pos++) begin
      slots[pos] = '0;
      slots[pos].slot_index = 3'(pos);
      locate_slot(item.bundle_pc, pos, base, tag);
      way = pick_way(base, tag, hit);
      if (hit) begin
        slots[pos].slot_hit = 1'b1;
        slots[pos].branch_kind = btb_kind[base + way];
        slots[pos].slot_target = btb_target[base + way];
        make_recent(base, way);
        if (btb_kind[base + way] == KIND_COND) begin
          taken = ctr[1:0] >= 2'd2;
          ctr = ctr >> 2;
          conds++;
          if (taken || conds == bundle_limit) begin
            done = 1'b1;
            len = 4'(pos + 1);
            next_pc = taken ? btb_target[base + way] : item.bundle_pc + 64'((pos + 1) * 4);
          end
        end else begin
          done = 1'b1;
          len = 4'(pos + 1);
          next_pc = btb_target[base + way];
        end
      end
    end
    slots[len - 1].last_slot = 1'b1;
    slots[len - 1].bundle_length = len;
    slots[len - 1].next_fetch_pc = next_pc;
    for (int pos = 0; pos < int'(len); pos++) expected_slots.push_back(slots[pos]);
  endfunction

  // Driver: presents queued transactions with random gaps between them.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_bundle(in_data);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = stall_enable ? $urandom_range(0, STALL_MAX) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expected slot.
  int recv_stall;
  always @(posedge clk) begin
    out_item_t exp_slot;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        slot_count++;
        if (expected_slots.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result %p", $time, out_data);
        end else begin
          exp_slot = expected_slots.pop_front();
          if (exp_slot.slot_index !== out_data.slot_index ||
              exp_slot.slot_hit !== out_data.slot_hit ||
              exp_slot.branch_kind !== out_data.branch_kind ||
              exp_slot.slot_target !== out_data.slot_target ||
              exp_slot.last_slot !== out_data.last_slot ||
              exp_slot.bundle_length !== out_data.bundle_length ||
              exp_slot.next_fetch_pc !== out_data.next_fetch_pc) begin
            error_count++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_slot, out_data);
          end
        end
        recv_stall = stall_enable ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] make_word(input logic [6:0] opc, input int rd_sel,
                                            input int rs1_sel);
    logic [31:0] w;
    w = $urandom;
    w[6:0] = opc;
    if (rd_sel == 0) w[11:7] = 5'd0;
    else if (rd_sel == 1) w[11:7] = 5'd1;
    if (rs1_sel == 1) w[19:15] = 5'd1;
    return w;
  endfunction

  function automatic logic [31:0] random_word();
    logic [6:0] opc;
    case ($urandom_range(0, 4))
      0: opc = OPC_BRANCH;
      1: opc = OPC_JAL;
      2, 3: opc = OPC_JALR;
      default: opc = 7'($urandom);
    endcase
    return make_word(opc, $urandom_range(0, 2), $urandom_range(0, 2));
  endfunction

  task automatic add_install(input logic [63:0] pc, input logic [2:0] slot,
                             input logic [63:0] target, input logic [31:0] word);
    in_item_t item;
    item = '0;
    item.operation = OP_INSTALL;
    item.bundle_pc = pc;
    item.miss_slot = slot;
    item.miss_target = target;
    item.instruction_word = word;
    item.taken_counters = 16'($urandom);
    pending_items.push_back(item);
  endtask

  task automatic add_lookup(input logic [63:0] pc, input logic [15:0] ctr);
    in_item_t item;
    item = '0;
    item.operation = OP_LOOKUP;
    item.bundle_pc = pc;
    item.taken_counters = ctr;
    item.miss_slot = 3'($urandom);
    item.miss_target = {$urandom, $urandom};
    item.instruction_word = $urandom;
    pending_items.push_back(item);
  endtask

  // Addresses drawn from a few hot regions, with tag aliases in the same set.
  function automatic logic [63:0] hot_pc();
    logic [63:0] base;
    case ($urandom_range(0, 4))
      0: base = 64'h0;
      1: base = 64'h1000;
      2: base = 64'hFFFF_FFFF_FFFF_FFE0;
      3: base = 64'h8000_0000_0004_0100;
      default: base = 64'h3FFF_FFFF_FFFF_F000;
    endcase
    return base + 64'($urandom_range(0, 5)) * 64'h800 + 64'($urandom_range(0, 31));
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_slots.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_LIMIT;
    pwdata <= 32'(value);
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bundle_limit = value;
  endtask

  task automatic random_phase(input int count);
    logic [63:0] pc;
    for (int i = 0; i < count; i++) begin
      pc = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : hot_pc();
      if ($urandom_range(0, 9) < 4)
        add_install(pc, 3'($urandom), {$urandom, $urandom}, random_word());
      else
        add_lookup(pc, ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom));
    end
  endtask

  initial begin
    logic [3:0] limits[6];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 1'b0;
    pwdata = '0;
    error_count = 0;
    lookup_count = 0;
    install_count = 0;
    slot_count = 0;
    quiet_cycles = 0;
    stall_enable = 1'b1;
    reset_shadow();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: every branch kind, a dropped opcode, misses, overwrite and eviction.
    add_lookup(64'h0, 16'h0);
    add_install(64'h1000, 3'd0, 64'h2000, make_word(OPC_BRANCH, 2, 2));
    add_install(64'h1000, 3'd1, 64'h3000, make_word(OPC_BRANCH, 2, 2));
    add_install(64'h1000, 3'd2, 64'h4000, make_word(OPC_JAL, 0, 2));
    add_install(64'h1000, 3'd3, 64'h5000, make_word(7'h13, 2, 2));
    add_lookup(64'h1000, 16'h0);
    add_lookup(64'h1000, 16'hFFFF);
    add_lookup(64'h1004, 16'h0);
    add_install(64'h2000, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, make_word(OPC_JAL, 1, 2));
    add_install(64'h2000, 3'd6, 64'h0, make_word(OPC_JALR, 0, 1));
    add_install(64'h2000, 3'd5, 64'h10, make_word(OPC_JALR, 1, 2));
    add_install(64'h2000, 3'd4, 64'h20, make_word(OPC_JALR, 5'd2, 2));
    add_lookup(64'h2010, 16'hAAAA);
    add_lookup(64'h2018, 16'h5555);
    add_lookup(64'h201C, 16'h0);
    add_install(64'h2000, 3'd7, 64'h1234, make_word(OPC_JALR, 0, 1));
    add_lookup(64'h201C, 16'h0);
    add_install(64'hFFFF_FFFF_FFFF_FFFC, 3'd1, 64'h40, make_word(OPC_BRANCH, 2, 2));
    add_lookup(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    for (int k = 0; k < 5; k++)
      add_install(64'h1000 + 64'(k) * 64'h800, 3'd0, 64'(k), make_word(OPC_JAL, 0, 2));
    add_lookup(64'h1000, 16'h0);
    add_lookup(64'h1800, 16'h0);
    stall_enable = 1'b0;
    wait_idle();

    // Random phases across several limits, with every third phase run as burst traffic.
    limits = '{4'd1, 4'd8, 4'd0, 4'd15, 4'($urandom_range(1, 8)), 4'd2};
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      stall_enable = (ph % 3) != 2;
      random_phase(73);
      wait_idle();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d lookups and %0d installs, %0d slot results checked.",
             lookup_count, install_count, slot_count);
    $display("Limits 0, 1, 2, 8 and 15 were used, with and without back-pressure.");
    if (error_count == 0 && expected_slots.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
